/* hw/rtl/sfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Constants and helpers for the sonar frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int unsigned POS_W = 17;
    localparam int unsigned LEN_W = 16;

    localparam logic [7:0] START_BYTE = 8'h40;
    localparam logic [7:0] END_BYTE   = 8'h0A;

    // Header layout positions.
    localparam logic [POS_W-1:0] POS_HEX_FIRST = 17'd1;
    localparam logic [POS_W-1:0] POS_HEX_LAST  = 17'd4;
    localparam logic [POS_W-1:0] POS_BIN_LO    = 17'd5;
    localparam logic [POS_W-1:0] POS_BIN_HI    = 17'd6;
    localparam logic [POS_W-1:0] POS_TYPE      = 17'd10;
    localparam logic [POS_W-1:0] POS_TOTAL_LO  = 17'd13;
    localparam logic [POS_W-1:0] POS_TOTAL_HI  = 17'd14;
    localparam logic [POS_W-1:0] POS_COUNT_LO  = 17'd42;
    localparam logic [POS_W-1:0] POS_COUNT_HI  = 17'd43;

    // The frame is the length plus six bytes; the last byte sits at length plus five.
    localparam logic [POS_W-1:0] SIZE_OFFSET = 17'd6;
    localparam logic [POS_W-1:0] LAST_OFFSET = 17'd5;

    localparam logic [POS_W-1:0] MIN_FRAME     = 17'd14;
    localparam logic [POS_W-1:0] SIZE_T19      = 17'd82;
    localparam logic [POS_W-1:0] SIZE_T25      = 17'd18;
    localparam logic [POS_W-1:0] SIZE_SMALL    = 17'd14;
    localparam logic [POS_W-1:0] SIZE_T1       = 17'd25;
    localparam logic [POS_W-1:0] SIZE_T4       = 17'd22;
    localparam logic [POS_W-1:0] SIZE_T6_A     = 17'd175;
    localparam logic [POS_W-1:0] SIZE_T6_B     = 17'd264;
    localparam logic [POS_W-1:0] T2_DATA_OFS   = 17'd45;
    localparam logic [POS_W-1:0] T2_TOTAL_OFS  = 17'd14;
    localparam logic [POS_W-1:0] T8_TOTAL_OFS  = 17'd16;

    // Packet type codes.
    localparam logic [7:0] KIND_1  = 8'd1;
    localparam logic [7:0] KIND_2  = 8'd2;
    localparam logic [7:0] KIND_4  = 8'd4;
    localparam logic [7:0] KIND_6  = 8'd6;
    localparam logic [7:0] KIND_8  = 8'd8;
    localparam logic [7:0] KIND_16 = 8'd16;
    localparam logic [7:0] KIND_19 = 8'd19;
    localparam logic [7:0] KIND_23 = 8'd23;
    localparam logic [7:0] KIND_24 = 8'd24;
    localparam logic [7:0] KIND_25 = 8'd25;

    // Verdict codes.
    localparam logic [2:0] VERDICT_GOOD      = 3'd0;
    localparam logic [2:0] VERDICT_NO_END    = 3'd1;
    localparam logic [2:0] VERDICT_BAD_SIZE  = 3'd2;
    localparam logic [2:0] VERDICT_SHORT     = 3'd3;
    localparam logic [2:0] VERDICT_LEN_DIFF  = 3'd4;

    // Returns {is_digit, value} for an ASCII hex character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
                hex_digit = {1'b1, d[3:0]};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h37;
                hex_digit = {1'b1, d[3:0]};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h57;
                hex_digit = {1'b1, d[3:0]};
            end
            else
            begin
                hex_digit = 5'd0;
            end
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/sonar_frame_deframer_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_frame_deframer_top
// Hunts for the start byte, checks the doubled length header and forwards
// every frame byte with its position and, on the last byte, a verdict.
// ----------------------------------------------------------------------------
// The result of each accepted frame byte is registered in the output register.
// Throughput: one byte per cycle unless a full, undrained output register stalls
// in_ready; the frame state and the result register are updated in the same cycle.
// Reset: asynchronous active-low reset returns to hunting and empties the
// output register; no clearing pass is needed.
module sonar_frame_deframer_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                rx_byte,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     frame_byte,
    output logic [sfd_pkg::POS_W-1:0]      byte_index,
    output logic                           frame_end,
    output logic [2:0]                     verdict,
    output logic [7:0]                     frame_kind
);
    import sfd_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic             hex_stop_reg, hex_stop_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [LEN_W-1:0] hex_length_reg, hex_length_next;
    logic [LEN_W-1:0] bin_length_reg, bin_length_next;
    logic [7:0]       type_byte_reg, type_byte_next;
    logic [LEN_W-1:0] inner_total_reg, inner_total_next;
    logic [LEN_W-1:0] inner_count_reg, inner_count_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       frame_byte_reg;
    logic [POS_W-1:0] byte_index_reg;
    logic             frame_end_reg;
    logic [2:0]       verdict_reg;
    logic [7:0]       frame_kind_reg;

    logic             accept;
    logic             emit;
    logic             end_c;
    logic [2:0]       verdict_c;
    logic [7:0]       kind_c;
    logic [POS_W-1:0] pos_c;
    logic [4:0]       digit;
    logic [LEN_W-1:0] bin_full;
    logic [POS_W-1:0] size_c;
    logic [POS_W-1:0] size16_c;
    logic [2:0]       size_verdict_c;

    // The output register is free when empty or being drained this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign digit    = hex_digit(rx_byte);
    assign bin_full = {rx_byte, bin_length_reg[7:0]};
    assign size_c   = {1'b0, bin_length_reg} + SIZE_OFFSET;
    assign size16_c = {1'b0, size_c[LEN_W-1:0]};

    // Size check against the inner fields as updated by the current byte.
    always_comb
    begin
        case (type_byte_reg)
            KIND_19: size_verdict_c = (size_c == SIZE_T19) ? VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_25: size_verdict_c = (size_c == SIZE_T25) ? VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_16, KIND_23, KIND_24:
                size_verdict_c = (size_c == SIZE_SMALL) ? VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_1:  size_verdict_c = (size_c == SIZE_T1) ? VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_4:  size_verdict_c = (size_c == SIZE_T4) ? VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_6:
                size_verdict_c = (size_c == SIZE_T6_A || size_c == SIZE_T6_B) ?
                                 VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_2:
                size_verdict_c = (size_c > T2_DATA_OFS &&
                                  size16_c == {1'b0, inner_count_next} + T2_DATA_OFS &&
                                  size16_c == {1'b0, inner_total_next} + T2_TOTAL_OFS) ?
                                 VERDICT_GOOD : VERDICT_BAD_SIZE;
            KIND_8:
                size_verdict_c = (size_c > T8_TOTAL_OFS &&
                                  size16_c == {1'b0, inner_total_next} + T8_TOTAL_OFS) ?
                                 VERDICT_GOOD : VERDICT_BAD_SIZE;
            default: size_verdict_c = VERDICT_GOOD;
        endcase
    end

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        hex_stop_next    = hex_stop_reg;
        position_next    = position_reg;
        hex_length_next  = hex_length_reg;
        bin_length_next  = bin_length_reg;
        type_byte_next   = type_byte_reg;
        inner_total_next = inner_total_reg;
        inner_count_next = inner_count_reg;
        emit             = 1'b0;
        end_c            = 1'b0;
        verdict_c        = VERDICT_GOOD;
        kind_c           = 8'd0;
        pos_c            = position_reg + 17'd1;

        if (!in_frame_reg)
        begin
            pos_c = '0;
            if (rx_byte == START_BYTE)
            begin
                emit             = 1'b1;
                in_frame_next    = 1'b1;
                hex_stop_next    = 1'b0;
                hex_length_next  = '0;
                bin_length_next  = '0;
                type_byte_next   = '0;
                inner_total_next = '0;
                inner_count_next = '0;
            end
        end
        else
        begin
            emit = 1'b1;
        end

        if (in_frame_reg)
        begin
            if (pos_c >= POS_HEX_FIRST && pos_c <= POS_HEX_LAST)
            begin
                if (!hex_stop_reg && digit[4])
                begin
                    hex_length_next = {hex_length_reg[LEN_W-5:0], digit[3:0]};
                end
                else
                begin
                    hex_stop_next = 1'b1;
                end
            end
            else if (pos_c == POS_BIN_LO)
            begin
                bin_length_next = {8'd0, rx_byte};
            end
            else if (pos_c == POS_BIN_HI)
            begin
                bin_length_next = bin_full;
                // A type byte is never known yet here, so the kind stays zero.
                if (bin_full != hex_length_reg)
                begin
                    end_c     = 1'b1;
                    verdict_c = VERDICT_LEN_DIFF;
                end
                else if ({1'b0, bin_full} + SIZE_OFFSET < MIN_FRAME)
                begin
                    end_c     = 1'b1;
                    verdict_c = VERDICT_SHORT;
                end
            end
            else if (pos_c > POS_BIN_HI)
            begin
                if (pos_c == POS_TYPE)
                begin
                    type_byte_next = rx_byte;
                end
                else if (pos_c == POS_TOTAL_LO)
                begin
                    inner_total_next = {8'd0, rx_byte};
                end
                else if (pos_c == POS_TOTAL_HI)
                begin
                    inner_total_next = {rx_byte, inner_total_reg[7:0]};
                end
                else if (pos_c == POS_COUNT_LO)
                begin
                    inner_count_next = {8'd0, rx_byte};
                end
                else if (pos_c == POS_COUNT_HI)
                begin
                    inner_count_next = {rx_byte, inner_count_reg[7:0]};
                end

                // The frame is at least fourteen bytes, so the type byte is
                // already registered when the last byte arrives.
                if (pos_c == {1'b0, bin_length_reg} + LAST_OFFSET)
                begin
                    end_c     = 1'b1;
                    kind_c    = type_byte_reg;
                    verdict_c = (rx_byte != END_BYTE) ? VERDICT_NO_END : size_verdict_c;
                end
            end
        end

        if (emit)
        begin
            position_next = pos_c;
        end
        if (end_c)
        begin
            in_frame_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            hex_stop_reg    <= 1'b0;
            position_reg    <= '0;
            hex_length_reg  <= '0;
            bin_length_reg  <= '0;
            type_byte_reg   <= '0;
            inner_total_reg <= '0;
            inner_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                in_frame_reg    <= in_frame_next;
                hex_stop_reg    <= hex_stop_next;
                position_reg    <= position_next;
                hex_length_reg  <= hex_length_next;
                bin_length_reg  <= bin_length_next;
                type_byte_reg   <= type_byte_next;
                inner_total_reg <= inner_total_next;
                inner_count_reg <= inner_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            frame_byte_reg <= rx_byte;
            byte_index_reg <= pos_c;
            frame_end_reg  <= end_c;
            verdict_reg    <= verdict_c;
            frame_kind_reg <= kind_c;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign byte_index = byte_index_reg;
    assign frame_end  = frame_end_reg;
    assign verdict    = verdict_reg;
    assign frame_kind = frame_kind_reg;

endmodule
`default_nettype wire
